/* design/stt_pkg.sv */
`timescale 1ns / 1ps
// stt_pkg: shared constants for the system tick timer.
// Operation and address codes, default sizes. No dependencies.
package stt_pkg;

    localparam int COUNTER_WIDTH   = 24;
    localparam int PRESCALE_DIVIDE = 8;
    localparam int WRAP_WIDTH      = 40;

    localparam int DATA_WIDTH = 32;
    localparam int READ_WIDTH = 64;
    localparam int FLAG_BIT   = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] ADDR_CTRL    = 2'd0;
    localparam logic [1:0] ADDR_RELOAD  = 2'd1;
    localparam logic [1:0] ADDR_CURRENT = 2'd2;
    localparam logic [1:0] ADDR_ELAPSED = 2'd3;

endpackage

/* design/system_tick_timer.sv */
`timescale 1ns / 1ps
// system_tick_timer: 24-bit down-counting tick timer with extended elapsed count.
// Depends on stt_pkg for codes and default sizes.
//
// Usage:
//   Request channel (cmd_valid / cmd_stall) carries one clock tick, one
//   register read or one register write per request (operation, address,
//   write_data). Result channel (res_valid / res_stall) returns exactly one
//   result per request: read_data and irq_pulse.
//   After acceptance the request passes the input register, then the
//   counter/register update that also loads the result register; res_valid
//   rises when the result register is loaded. Throughput is one request per
//   cycle while the receiver does not stall; the state update is a single
//   decrement, reload, flag clear or register write.
//   When the receiver stalls, the result register holds; the input register
//   fills, and cmd_stall rises while both are occupied and res_stall is high.
//   Reset clears the control bits, flag, reload and current value, the
//   prescaler, and sets the wrap counter to one; both stages come up empty.
module system_tick_timer #(
    parameter int COUNTER_WIDTH   = stt_pkg::COUNTER_WIDTH,
    parameter int PRESCALE_DIVIDE = stt_pkg::PRESCALE_DIVIDE,
    parameter int WRAP_WIDTH      = stt_pkg::WRAP_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [1:0]                      operation,
    input  logic [1:0]                      address,
    input  logic [stt_pkg::DATA_WIDTH-1:0]  write_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [stt_pkg::READ_WIDTH-1:0]  read_data,
    output logic                            irq_pulse
);

    localparam int PRE_W = $clog2(PRESCALE_DIVIDE);
    localparam int EXT_W = WRAP_WIDTH + COUNTER_WIDTH;
    localparam int SUM_W = (EXT_W > stt_pkg::READ_WIDTH) ? EXT_W : stt_pkg::READ_WIDTH;

    // input register
    logic                           s1_valid_reg;
    logic [1:0]                     s1_op_reg;
    logic [1:0]                     s1_addr_reg;
    logic [stt_pkg::DATA_WIDTH-1:0] s1_data_reg;

    // timer state
    logic                     run_enable_reg, run_enable_next;
    logic                     irq_enable_reg, irq_enable_next;
    logic                     clk_src_full_reg, clk_src_full_next;
    logic                     count_flag_reg, count_flag_next;
    logic [COUNTER_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNTER_WIDTH-1:0] current_reg, current_next;
    logic [WRAP_WIDTH-1:0]    wrap_reg, wrap_next;
    logic [PRE_W-1:0]         prescale_reg, prescale_next;

    // result register
    logic                           res_valid_reg;
    logic [stt_pkg::READ_WIDTH-1:0] read_data_reg, read_data_next;
    logic                           irq_reg, irq_next;

    logic cmd_fire;
    logic s1_fire;
    logic step;
    logic [SUM_W-1:0] elapsed;

    assign s1_fire   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && res_valid_reg && res_stall;
    assign cmd_fire  = cmd_valid && !cmd_stall;

    assign res_valid = res_valid_reg;
    assign read_data = read_data_reg;
    assign irq_pulse = irq_reg;

    assign elapsed = (SUM_W'(wrap_reg) << COUNTER_WIDTH) - SUM_W'(current_reg);

    always_comb
    begin
        run_enable_next   = run_enable_reg;
        irq_enable_next   = irq_enable_reg;
        clk_src_full_next = clk_src_full_reg;
        count_flag_next   = count_flag_reg;
        reload_next       = reload_reg;
        current_next      = current_reg;
        wrap_next         = wrap_reg;
        prescale_next     = prescale_reg;
        read_data_next    = '0;
        irq_next          = 1'b0;
        step              = 1'b0;

        unique case (s1_op_reg)
            stt_pkg::OP_TICK:
            begin
                if (run_enable_reg)
                begin
                    if (clk_src_full_reg)
                    begin
                        step = 1'b1;
                    end
                    else
                    begin
                        if (prescale_reg == PRE_W'(PRESCALE_DIVIDE - 1))
                        begin
                            prescale_next = '0;
                            step          = 1'b1;
                        end
                        else
                        begin
                            prescale_next = prescale_reg + 1'b1;
                        end
                    end
                    if (step)
                    begin
                        if (current_reg == '0)
                        begin
                            current_next = reload_reg;
                        end
                        else
                        begin
                            current_next = current_reg - 1'b1;
                            if (current_reg == COUNTER_WIDTH'(1))
                            begin
                                count_flag_next = 1'b1;
                                wrap_next       = wrap_reg + 1'b1;
                                irq_next        = irq_enable_reg;
                            end
                        end
                    end
                end
            end
            stt_pkg::OP_READ:
            begin
                unique case (s1_addr_reg)
                    stt_pkg::ADDR_CTRL:
                    begin
                        read_data_next[0]                = run_enable_reg;
                        read_data_next[1]                = irq_enable_reg;
                        read_data_next[2]                = clk_src_full_reg;
                        read_data_next[stt_pkg::FLAG_BIT] = count_flag_reg;
                        count_flag_next                  = 1'b0;
                    end
                    stt_pkg::ADDR_RELOAD:
                        read_data_next = stt_pkg::READ_WIDTH'(reload_reg);
                    stt_pkg::ADDR_CURRENT:
                        read_data_next = stt_pkg::READ_WIDTH'(current_reg);
                    default:
                        read_data_next = elapsed[stt_pkg::READ_WIDTH-1:0];
                endcase
            end
            stt_pkg::OP_WRITE:
            begin
                unique case (s1_addr_reg)
                    stt_pkg::ADDR_CTRL:
                    begin
                        run_enable_next   = s1_data_reg[0];
                        irq_enable_next   = s1_data_reg[1];
                        clk_src_full_next = s1_data_reg[2];
                    end
                    stt_pkg::ADDR_RELOAD:
                        reload_next = s1_data_reg[COUNTER_WIDTH-1:0];
                    stt_pkg::ADDR_CURRENT:
                    begin
                        current_next    = '0;
                        count_flag_next = 1'b0;
                    end
                    default:
                        wrap_next = WRAP_WIDTH'(1);
                endcase
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            run_enable_reg   <= 1'b0;
            irq_enable_reg   <= 1'b0;
            clk_src_full_reg <= 1'b0;
            count_flag_reg   <= 1'b0;
            reload_reg       <= '0;
            current_reg      <= '0;
            wrap_reg         <= WRAP_WIDTH'(1);
            prescale_reg     <= '0;
        end
        else
        begin
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                res_valid_reg    <= 1'b1;
                run_enable_reg   <= run_enable_next;
                irq_enable_reg   <= irq_enable_next;
                clk_src_full_reg <= clk_src_full_next;
                count_flag_reg   <= count_flag_next;
                reload_reg       <= reload_next;
                current_reg      <= current_next;
                wrap_reg         <= wrap_next;
                prescale_reg     <= prescale_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_op_reg   <= operation;
            s1_addr_reg <= address;
            s1_data_reg <= write_data;
        end
        if (s1_fire)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

`ifndef ASSERT_OFF
    // irq only on a step that lands on zero, which also sets the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && irq_next |=> current_reg == '0 && count_flag_reg)
        else $error("irq without counter reaching zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_op_reg == stt_pkg::OP_WRITE && s1_addr_reg == stt_pkg::ADDR_CURRENT
        |=> current_reg == '0 && !count_flag_reg)
        else $error("current write did not clear counter and flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_op_reg == stt_pkg::OP_TICK && !run_enable_reg
        |=> $stable(current_reg) && $stable(prescale_reg) && $stable(wrap_reg))
        else $error("disabled tick changed counter state");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg && res_valid_reg)
        else $error("request stalled with a free stage");
`endif

endmodule
